[hdl/asc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package asc_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 10;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int unsigned MAG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [15:0] THRESHOLD_RST    = 16'd1229;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd300;
  localparam logic [11:0] STRIDE_RST       = 12'd700;
  localparam logic [15:0] ENERGY_RST       = 16'd40;
  localparam logic [31:0] STILL_LIMIT_RST  = 32'd10486;
  localparam logic [31:0] RUN_LIMIT_RST    = 32'd524288;

  // x/5 as (x * 52429) >> 18, exact for the 18-bit values of threshold*4
  localparam logic [17:0] DIV5_MUL   = 18'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  localparam logic [1:0] ACT_STILL = 2'd0;
  localparam logic [1:0] ACT_WALK  = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_MIN_INTERVAL = 3'd1,
    REG_STRIDE       = 3'd2,
    REG_ENERGY       = 3'd3,
    REG_STILL_LIMIT  = 3'd4,
    REG_RUN_LIMIT    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] min_interval;
    logic [11:0] stride;
    logic [15:0] energy;
    logic [31:0] still_limit;
    logic [31:0] run_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sq;
    logic [31:0] time_ms;
  } item_t;

endpackage
`default_nettype wire

[hdl/asc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface asc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [31:0] time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface asc_out_if;
  logic        valid;
  logic        ready;
  logic        step_detected;
  logic [31:0] step_total;
  logic [43:0] distance_mm;
  logic [47:0] energy_used;
  logic [1:0]  activity;

  modport source (output valid, step_detected, step_total, distance_mm, energy_used,
                  activity, input ready);
  modport sink   (input valid, step_detected, step_total, distance_mm, energy_used,
                  activity, output ready);
endinterface
`default_nettype wire

[hdl/accel_step_counter.sv]
// Step counter for a three-axis accelerometer.
// in_ch: one sample per transfer (accel_x/y/z signed 1/1024 g, time_ms tick).
// out_ch: one result per sample: step flag, step total, distance, energy and
// activity class, in sample order.
// cfg_we/cfg_idx/cfg_wdata write the six registers; write only while idle.
// The sample rate is set by the bit-serial square root in the back end plus
// the window and variance steps. The front end squares one axis per cycle
// and hands the sum of squares over to the back end through the queue.
// A two-entry queue sits between front and back, so the front takes a new
// sample while the back works. When the receiver stalls, the result holds in
// the output register, the back end waits, then the queue and front fill and
// in_ch.ready drops.
// Reset restores register defaults and clears filter, counts and window; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module accel_step_counter #(
  parameter int unsigned WINDOW_LEN = asc_pkg::WINDOW_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  asc_in_if.sink                          in_ch,
  asc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import asc_pkg::*;

  cfg_t   cfg_r;
  item_t  f_item;
  item_t  q_head;
  logic   q_push;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{threshold: THRESHOLD_RST, min_interval: MIN_INTERVAL_RST,
                 stride: STRIDE_RST, energy: ENERGY_RST,
                 still_limit: STILL_LIMIT_RST, run_limit: RUN_LIMIT_RST};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD:    cfg_r.threshold    <= cfg_wdata[15:0];
        REG_MIN_INTERVAL: cfg_r.min_interval <= cfg_wdata[15:0];
        REG_STRIDE:       cfg_r.stride       <= cfg_wdata[11:0];
        REG_ENERGY:       cfg_r.energy       <= cfg_wdata[15:0];
        REG_STILL_LIMIT:  cfg_r.still_limit  <= cfg_wdata;
        REG_RUN_LIMIT:    cfg_r.run_limit    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_item (f_item),
    .q_push (q_push),
    .q_full (q_full)
  );

  asc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  asc_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_item  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.activity != 2'd3)) else $error("bad activity code");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("output valid after reset");

endmodule
`default_nettype wire

[hdl/asc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module asc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 10,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/asc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module asc_front (
  input  logic           clk,
  input  logic           rst_n,
  asc_in_if.sink         in_ch,
  output asc_pkg::item_t q_item,
  output logic           q_push,
  input  logic           q_full
);
  import asc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SQR, F_PUSH} fstate_t;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  fstate_t            state_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic        [31:0] time_r;
  logic        [31:0] acc_r;
  logic        [1:0]  axis_r;
  logic signed [31:0] cur;
  logic        [31:0] sqr;

  assign in_ch.ready = (state_r == F_IDLE);
  assign q_push      = (state_r == F_PUSH) && !q_full;
  assign q_item      = '{sq: acc_r, time_ms: time_r};

  always_comb begin
    unique case (axis_r)
      AXIS_X:  cur = 32'(ax_r);
      AXIS_Y:  cur = 32'(ay_r);
      default: cur = 32'(az_r);
    endcase
    sqr = $unsigned(cur * cur);
  end

  // square one axis per cycle and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            ax_r    <= in_ch.accel_x;
            ay_r    <= in_ch.accel_y;
            az_r    <= in_ch.accel_z;
            time_r  <= in_ch.time_ms;
            acc_r   <= '0;
            axis_r  <= AXIS_X;
            state_r <= F_SQR;
          end
        end
        F_SQR: begin
          acc_r <= acc_r + sqr;
          if (axis_r == AXIS_Z) begin
            state_r <= F_PUSH;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/asc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module asc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  asc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output asc_pkg::item_t head,
  output logic           empty
);
  import asc_pkg::*;

  item_t                ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_PTR_W:0]     cnt_r;

  assign full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[hdl/asc_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module asc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] rad_r;
  logic [17:0] rem_r;
  logic [15:0] root_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [19:0] rem_sh;
  logic [19:0] trial;

  assign rem_sh = {rem_r, rad_r[31:30]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign done   = done_r;
  assign root   = root_r;

  // one root bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rad_r <= {rad_r[29:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= 18'(rem_sh - trial);
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[17:0];
          root_r <= {root_r[14:0], 1'b0};
        end
        cnt_r  <= cnt_r + 4'd1;
        done_r <= (cnt_r == 4'd15);
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/asc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module asc_back #(
  parameter int unsigned WINDOW_LEN = asc_pkg::WINDOW_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  asc_pkg::cfg_t  cfg,
  input  asc_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           q_pop,
  asc_out_if.source      out_ch
);
  import asc_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W  = MAG_W + SLOT_W;
  localparam int unsigned SQS_W  = 2 * MAG_W + SLOT_W;
  localparam int unsigned D_W    = 2 * SUM_W;
  localparam logic [D_W-1:0]    N_D    = D_W'(WINDOW_LEN);
  localparam logic [D_W-1:0]    N2_D   = D_W'(WINDOW_LEN * WINDOW_LEN);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

  typedef enum logic [2:0] {S_IDLE, S_ROOT, S_MAG, S_WIN, S_SUMS, S_VAR, S_OUT} bstate_t;

  bstate_t           state_r;
  logic [23:0]       filt_r;
  logic [31:0]       p179_r;
  logic              armed_r;
  logic [31:0]       last_r;
  logic [31:0]       count_r;
  logic [31:0]       time_r;
  logic [SLOT_W-1:0] slot_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQS_W-1:0]  sqs_r;
  logic [MAG_W-1:0]  m_r;
  logic [MAG_W-1:0]  old_r;
  logic [31:0]       msq_r;
  logic [D_W-1:0]    sumsq_r;
  logic [43:0]       dist_r;
  logic [47:0]       energy_r;
  logic              fired_r;
  logic [15:0]       end_thr_r;
  logic              out_valid_r;
  logic              out_fired_r;
  logic [31:0]       out_total_r;
  logic [43:0]       out_dist_r;
  logic [47:0]       out_energy_r;
  logic [1:0]        out_act_r;

  logic              sq_done;
  logic [15:0]       sq_root;
  logic [MAG_W-1:0]  ram_rdata;
  logic              ram_we;
  logic [23:0]       filt_nxt;
  logic [35:0]       div5_prod;
  logic [31:0]       oldsq;
  logic [D_W-1:0]    d_val;
  logic [1:0]        act;
  logic              out_free;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign ram_we   = (state_r == S_SUMS);
  assign out_free = !out_valid_r || out_ch.ready;

  asc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_pop),
    .radicand (q_item.sq),
    .done     (sq_done),
    .root     (sq_root)
  );

  asc_ram #(.WIDTH(MAG_W), .DEPTH(WINDOW_LEN), .ADDR_W(SLOT_W)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (m_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    filt_nxt  = 24'(32'(77 * sq_root) + (p179_r >> 8));
    div5_prod = {cfg.threshold, 2'b00} * DIV5_MUL;
    oldsq     = old_r * old_r;
    d_val     = D_W'(N_D * D_W'(sqs_r)) - sumsq_r;
    if (d_val < D_W'(N2_D * D_W'(cfg.still_limit))) begin
      act = ACT_STILL;
    end else if (d_val < D_W'(N2_D * D_W'(cfg.run_limit))) begin
      act = ACT_WALK;
    end else begin
      act = ACT_RUN;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_detected = out_fired_r;
  assign out_ch.step_total    = out_total_r;
  assign out_ch.distance_mm   = out_dist_r;
  assign out_ch.energy_used   = out_energy_r;
  assign out_ch.activity      = out_act_r;

  always_ff @(posedge clk) begin
    end_thr_r <= div5_prod[DIV5_SHIFT +: 16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filt_r      <= '0;
      armed_r     <= 1'b0;
      last_r      <= '0;
      count_r     <= '0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      sqs_r       <= '0;
      fired_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            p179_r  <= 32'(filt_r) * 32'd179;
            time_r  <= q_item.time_ms;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            state_r <= S_MAG;
          end
        end
        S_MAG: begin
          m_r    <= sq_root;
          filt_r <= filt_nxt;
          old_r  <= full_r ? ram_rdata : '0;
          if (!armed_r && (filt_nxt > {cfg.threshold, 8'h00})) begin
            armed_r <= 1'b1;
            fired_r <= 1'b0;
          end else if (armed_r && (filt_nxt < {end_thr_r, 8'h00})) begin
            if ((time_r - last_r) >= 32'(cfg.min_interval)) begin
              count_r <= count_r + 32'd1;
              last_r  <= time_r;
              fired_r <= 1'b1;
            end else begin
              fired_r <= 1'b0;
            end
            armed_r <= 1'b0;
          end else begin
            fired_r <= 1'b0;
          end
          state_r <= S_WIN;
        end
        S_WIN: begin
          msq_r   <= m_r * m_r;
          state_r <= S_SUMS;
        end
        S_SUMS: begin
          sum_r  <= sum_r - SUM_W'(old_r) + SUM_W'(m_r);
          sqs_r  <= sqs_r - SQS_W'(oldsq) + SQS_W'(msq_r);
          dist_r <= 44'(count_r) * 44'(cfg.stride);
          if (slot_r == SLOT_LAST) begin
            slot_r <= '0;
            full_r <= 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
          state_r <= S_VAR;
        end
        S_VAR: begin
          sumsq_r  <= D_W'(sum_r) * D_W'(sum_r);
          energy_r <= 48'(count_r) * 48'(cfg.energy);
          state_r  <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_fired_r  <= fired_r;
            out_total_r  <= count_r;
            out_dist_r   <= dist_r;
            out_energy_r <= energy_r;
            out_act_r    <= act;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
